// ===== src/sfn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfn_pkg
// shared constants, types and helpers of the 8.3 short name generator
// ----------------------------------------------------------------------------
package sfn_pkg;

    localparam int SHORT_NAME_LEN = 8;
    localparam int EXT_LEN        = 3;
    localparam int SNAP_LEN       = SHORT_NAME_LEN + EXT_LEN;
    localparam int CNT_W          = $clog2(SHORT_NAME_LEN + 1);
    localparam int BEAT_W         = $clog2(SNAP_LEN);
    localparam int ECNT_W         = $clog2(EXT_LEN + 1);

    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    typedef struct packed {
        logic                           invalid;
        logic [SNAP_LEN-1:0][7:0]       bytes;
    } t_snap;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            r = c - CH_LOWER_A + CH_UPPER_A;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/sfn_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfn_accum
// collects name and extension bytes, builds the short name on the last beat
// ----------------------------------------------------------------------------
module sfn_accum (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_beat,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    output logic               o_load,
    output sfn_pkg::t_snap     o_snap
);
    import sfn_pkg::*;

    logic [SHORT_NAME_LEN-1:0][7:0] r_kept;
    logic [CNT_W-1:0]               r_cnt;
    logic [CNT_W-1:0]               r_cad;
    logic                           r_dot;
    logic [EXT_LEN-1:0][7:0]        r_ext;
    logic [ECNT_W-1:0]              r_ecnt;
    logic                           r_first;
    logic                           r_swd;

    logic [SHORT_NAME_LEN-1:0][7:0] n_kept;
    logic [CNT_W-1:0]               n_cnt;
    logic [CNT_W-1:0]               n_cad;
    logic                           n_dot;
    logic [EXT_LEN-1:0][7:0]        n_ext;
    logic [ECNT_W-1:0]              n_ecnt;
    logic                           n_swd;
    logic                           is_dot;
    logic                           kept_wr;
    logic                           ext_wr;
    logic [CNT_W-1:0]               name_len;

    assign is_dot  = (i_byte == CH_DOT);
    assign kept_wr = !is_dot && (i_byte != CH_SPACE) && (r_cnt < CNT_W'(SHORT_NAME_LEN));
    assign ext_wr  = !is_dot && r_dot && (r_ecnt < ECNT_W'(EXT_LEN));

    always_comb begin
        n_kept = r_kept;
        n_ext  = r_ext;
        n_cnt  = r_cnt;
        n_cad  = r_cad;
        n_dot  = r_dot || is_dot;
        n_ecnt = r_ecnt;
        n_swd  = r_swd || (r_first && is_dot);
        for (int i = 0; i < SHORT_NAME_LEN; i++) begin
            if (kept_wr && r_cnt == CNT_W'(i)) begin
                n_kept[i] = i_byte;
            end
        end
        if (kept_wr) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (is_dot) begin
            n_cad  = r_cnt;
            n_ecnt = '0;
            for (int j = 0; j < EXT_LEN; j++) begin
                n_ext[j] = CH_SPACE;
            end
        end else if (ext_wr) begin
            for (int j = 0; j < EXT_LEN; j++) begin
                if (r_ecnt == ECNT_W'(j)) begin
                    n_ext[j] = i_byte;
                end
            end
            n_ecnt = r_ecnt + 1'b1;
        end
    end

    assign name_len = n_dot ? n_cad : n_cnt;

    always_comb begin
        o_snap.invalid = n_swd;
        for (int i = 0; i < SHORT_NAME_LEN; i++) begin
            o_snap.bytes[i] = (CNT_W'(i) < name_len) ? to_upper(n_kept[i]) : CH_SPACE;
        end
        for (int j = 0; j < EXT_LEN; j++) begin
            o_snap.bytes[SHORT_NAME_LEN + j] = to_upper(n_ext[j]);
        end
    end

    assign o_load = i_beat && i_last;

    always_ff @(posedge i_clk) begin
        if (i_beat) begin
            r_kept <= n_kept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat && i_last)) begin
            r_cnt   <= '0;
            r_cad   <= '0;
            r_dot   <= 1'b0;
            r_ecnt  <= '0;
            r_first <= 1'b1;
            r_swd   <= 1'b0;
            for (int j = 0; j < EXT_LEN; j++) begin
                r_ext[j] <= CH_SPACE;
            end
        end else if (i_beat) begin
            r_cnt   <= n_cnt;
            r_cad   <= n_cad;
            r_dot   <= n_dot;
            r_ecnt  <= n_ecnt;
            r_first <= 1'b0;
            r_swd   <= n_swd;
            r_ext   <= n_ext;
        end
    end

endmodule
`default_nettype wire

// ===== src/sfn_serial.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfn_serial
// holds one finished short name and shifts it out beat by beat
// ----------------------------------------------------------------------------
module sfn_serial (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire sfn_pkg::t_snap i_snap,
    output logic                o_free,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [7:0]          o_tdata,
    output logic                o_tuser,
    output logic                o_tlast
);
    import sfn_pkg::*;

    logic [SNAP_LEN-1:0][7:0] r_bytes;
    logic                     r_invalid;
    logic                     r_valid;
    logic [BEAT_W-1:0]        r_beat;
    logic                     out_beat;

    assign out_beat = r_valid && i_tready;
    assign o_tvalid = r_valid;
    assign o_tuser  = r_invalid;
    assign o_tdata  = r_invalid ? 8'h00 : r_bytes[0];
    assign o_tlast  = r_invalid || (r_beat == BEAT_W'(SNAP_LEN - 1));
    assign o_free   = !r_valid || (out_beat && o_tlast);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes   <= i_snap.bytes;
            r_invalid <= i_snap.invalid;
        end else if (out_beat) begin
            r_bytes   <= r_bytes >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= '0;
        end else if (out_beat) begin
            if (o_tlast) begin
                r_valid <= 1'b0;
            end
            r_beat <= r_beat + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== src/short_name_from_long_name_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// short_name_from_long_name_core
// turns a long file name, one byte per beat, into an 8.3 short name
// ----------------------------------------------------------------------------
// first result beat appears in the cycle after the last name byte is taken
// throughput: one name byte per cycle; a finished name then drives 11 beats
//   (one for a leading-dot name); bytes of the next name keep flowing, only
//   its last byte waits until the final beat of the previous name leaves
// reset: synchronous active low, clears all control state; kept name bytes
//   are not reset
// ----------------------------------------------------------------------------
module short_name_from_long_name_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] name_byte
    input  wire logic       i_s_tlast,
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] short_byte
    output logic            o_m_tuser,   // [0] invalid_name
    output logic            o_m_tlast
);
    import sfn_pkg::*;

    logic  in_beat;
    logic  load;
    logic  free;
    t_snap snap;

    // only a last byte needs the output register to be free
    assign o_s_tready = free || !i_s_tlast;
    assign in_beat    = i_s_tvalid && o_s_tready;

    sfn_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (in_beat),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_load  (load),
        .o_snap  (snap)
    );

    sfn_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_snap   (snap),
        .o_free   (free),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire
